>>> hdl/sdwr_pkg.sv
// shared types and constants for the card dealer
package sdwr_pkg;

  localparam int unsigned CARD_W    = 7;
  localparam int unsigned RND_W     = 31;
  localparam int unsigned DIV_STEPS = RND_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef logic [CARD_W-1:0] card_t;

  localparam card_t DECK_RESET = card_t'(52);

  // control broadcast along the row of list cells
  typedef struct packed {
    logic  load;
    logic  shift;
    card_t pos;
  } cell_ctrl_t;

endpackage

>>> hdl/sdwr_cell.sv
// one list cell: holds an entry, refills with its card number, shifts down
module sdwr_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  sdwr_pkg::cell_ctrl_t ctrl,
  input  sdwr_pkg::card_t    nbr_val,
  output sdwr_pkg::card_t    val,
  output sdwr_pkg::card_t    tap
);
  import sdwr_pkg::*;

  card_t val_r;
  card_t val_nxt;
  logic  match;
  logic  at_or_above;

  assign match       = (32'(ctrl.pos) == 32'(IDX));
  assign at_or_above = (32'(ctrl.pos) <= 32'(IDX));

  always_comb begin
    val_nxt = val_r;
    if (ctrl.load) begin
      val_nxt = card_t'(IDX + 1);
    end else if (ctrl.shift && at_or_above) begin
      // close the gap left by the drawn entry
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign tap = match ? val_r : '0;

endmodule

>>> hdl/sdwr_div.sv
// bit-serial remainder unit: dividend modulo a 7-bit divisor, one bit per cycle
module sdwr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sdwr_pkg::RND_W-1:0] dividend,
  input  sdwr_pkg::card_t            divisor,
  output logic                       done,
  output sdwr_pkg::card_t            rem
);
  import sdwr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [RND_W-1:0]  dvd_r;
  card_t             dsr_r;
  card_t             rem_r;
  card_t             rem_nxt;
  logic [CARD_W:0]   trial;
  logic [CARD_W:0]   diff;

  assign trial = {rem_r, dvd_r[RND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  // partial remainder stays below the divisor, so trial is below twice it
  always_comb begin
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[CARD_W-1:0];
    end else begin
      rem_nxt = trial[CARD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> hdl/shuffle_draw_without_replacement.sv
// draw path from input beat to out_valid: remainder steps, done, pick, write-out
// restart and empty-list draw: from the input beat through S_OUT straight to the output register
// one item in flight: in_ready stays low from an accepted draw or restart until S_OUT hands on the result
// the 31-step bit-serial remainder unit sets the draw time
// rst_n (synchronous, active low) clears count, control and sets deck size to 52
// list contents are not cleared by reset; a restart loads every cell from the accepted input beat
module shuffle_draw_without_replacement #(
  parameter int unsigned MAX_CARDS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [sdwr_pkg::RND_W-1:0] in_random_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sdwr_pkg::card_t            out_drawn_card,
  output logic                       out_last_card,
  output logic                       out_empty_error,
  input  logic                       cfg_wr_en,
  input  sdwr_pkg::card_t            cfg_wr_data
);
  import sdwr_pkg::*;

  localparam int unsigned GRP  = 8;
  localparam int unsigned NGRP = (MAX_CARDS + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PICK,
    S_OUT
  } state_t;

  state_t     state_r;
  card_t      deck_r;
  card_t      count_r;
  card_t      res_card_r;
  logic       res_last_r;
  logic       res_err_r;
  logic       out_valid_r;
  card_t      out_card_r;
  logic       out_last_r;
  logic       out_err_r;

  card_t      load_n;
  logic       accept;
  logic       div_start;
  logic       div_done;
  card_t      div_rem;
  cell_ctrl_t ctrl;
  card_t      vals [MAX_CARDS];
  card_t      taps [MAX_CARDS];
  card_t      grp_r [NGRP];
  card_t      picked;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign div_start = accept && in_mode && (count_r != '0);
  assign load_n    = (32'(deck_r) > 32'(MAX_CARDS)) ? card_t'(MAX_CARDS) : deck_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deck_r <= DECK_RESET;
    end else if (cfg_wr_en) begin
      deck_r <= cfg_wr_data;
    end
  end

  sdwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_random_word),
    .divisor  (count_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    ctrl.load  = accept && !in_mode;
    ctrl.shift = (state_r == S_PICK);
    ctrl.pos   = div_rem;
  end

  for (genvar i = 0; i < MAX_CARDS; i++) begin : g_cell
    card_t nbr;
    if (i == MAX_CARDS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = vals[i+1];
    end
    sdwr_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .nbr_val (nbr),
      .val     (vals[i]),
      .tap     (taps[i])
    );
  end

  // first level of the pick tree: each group ORs its taps into one register
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      card_t acc;
      acc = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < MAX_CARDS) begin
          acc = acc | taps[g * GRP + k];
        end
      end
      grp_r[g] <= acc;
    end
  end

  always_comb begin
    picked = '0;
    for (int g = 0; g < NGRP; g++) begin
      picked = picked | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT handles the output register itself
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_card_r <= '0;
            res_last_r <= 1'b0;
            res_err_r  <= in_mode && (count_r == '0);
            if (!in_mode) begin
              count_r <= load_n;
              state_r <= S_OUT;
            end else if (count_r == '0) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          res_card_r <= picked;
          res_last_r <= (count_r == card_t'(1));
          count_r    <= count_r - 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_card_r  <= res_card_r;
            out_last_r  <= res_last_r;
            out_err_r   <= res_err_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_card  = out_card_r;
  assign out_last_card   = out_last_r;
  assign out_empty_error = out_err_r;

endmodule

>>> hdl/sdwr_checker.sv
// port-level checks for the card dealer, bound to the top level
module sdwr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input sdwr_pkg::card_t            out_drawn_card,
  input logic                       out_last_card,
  input logic                       out_empty_error
);
  import sdwr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drawn_card)
      && $stable(out_last_card) && $stable(out_empty_error))
    else $error("result beat changed while stalled");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |-> out_drawn_card == '0 && !out_last_card)
    else $error("error beat carries a card");

  // a draw that empties the list always yields a real card
  a_last_card: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_card |-> out_drawn_card != '0 && !out_empty_error)
    else $error("last card beat without a card");

endmodule

bind shuffle_draw_without_replacement sdwr_checker u_sdwr_checker (.*);
